// ----- rtl/udc_pkg.sv -----
// shared types, constants and the ones'-complement add for the udp checksum checker
// no dependencies; used by udc_front, udc_queue, udc_back and the top level
package udc_pkg;

  // default datagram size limit in bytes
  localparam int unsigned DEF_MAX_BYTES = 65535;
  // byte counter width: holds the largest limit plus one (saturation value)
  localparam int unsigned TOTAL_W = 17;
  localparam int unsigned HDR_BYTES = 8;
  localparam logic [31:0] UDP_PROTO = 32'd17;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_MISMATCH  = 2'd2;
  localparam logic [1:0] ST_OVERSIZE  = 2'd3;

  // header word positions
  localparam int unsigned HW_SRC = 0;
  localparam int unsigned HW_DST = 1;
  localparam int unsigned HW_LEN = 2;
  localparam int unsigned HW_CHK = 3;

  // finished datagram handed from front to back
  typedef struct packed {
    logic [31:0]          sum;
    logic [7:0]           pend;
    logic [31:0]          pseudo;
    logic [3:0][15:0]     hw;
    logic [TOTAL_W-1:0]   total;
    logic                 gen;
  } rec_t;

  // sideband carried down the back pipeline
  typedef struct packed {
    logic [15:0]          n16;
    logic [3:0][15:0]     hw;
    logic [1:0]           pre;
    logic                 verify;
  } info_t;

  // 32-bit add with end-around carry
  function automatic logic [31:0] add_oc(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[31:0] + {31'b0, t[32]};
  endfunction

endpackage

// ----- rtl/udc_front.sv -----
// front part: takes datagram bytes, captures the header and keeps the running payload sum
// depends on udc_pkg; pushes one record per datagram into udc_queue
module udc_front #(
  parameter int unsigned MAX_DATAGRAM_BYTES = udc_pkg::DEF_MAX_BYTES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           generate_mode,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_data_byte,
  input  logic           in_first_byte,
  input  logic           in_last_byte,
  input  logic [31:0]    in_pseudo_sum,
  input  logic           q_full,
  output logic           q_push,
  output udc_pkg::rec_t  q_rec
);
  import udc_pkg::*;

  logic [31:0]        sum_r, sum_nxt;
  logic [TOTAL_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]         pend_r, pend_nxt;
  logic [3:0][15:0]   hw_r, hw_nxt;
  logic [31:0]        pseudo_r, pseudo_nxt;

  logic [TOTAL_W-1:0] idx;
  logic [15:0]        len;
  logic               bounded;
  logic               accept;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;

  // per-byte update of the datagram state
  always_comb begin
    sum_nxt    = in_first_byte ? 32'h0 : sum_r;
    idx        = in_first_byte ? '0 : cnt_r;
    pend_nxt   = in_first_byte ? 8'h0 : pend_r;
    hw_nxt     = in_first_byte ? '0 : hw_r;
    pseudo_nxt = in_first_byte ? in_pseudo_sum : pseudo_r;
    len        = hw_nxt[HW_LEN];
    bounded    = ~generate_mode & (len != 16'h0);
    if (32'(idx) < MAX_DATAGRAM_BYTES) begin
      if (32'(idx) < HDR_BYTES) begin
        if (!idx[0]) begin
          hw_nxt[idx[2:1]][15:8] = in_data_byte;
        end else begin
          hw_nxt[idx[2:1]][7:0] = in_data_byte;
        end
      end else if (!bounded || (32'(idx) < 32'(len))) begin
        if (!idx[0]) begin
          pend_nxt = in_data_byte;
        end else begin
          sum_nxt = add_oc(sum_nxt, {16'h0, pend_nxt, in_data_byte});
        end
      end
    end
    // counter saturates one past the limit
    if (32'(idx) <= MAX_DATAGRAM_BYTES) begin
      cnt_nxt = idx + TOTAL_W'(1);
    end else begin
      cnt_nxt = idx;
    end
  end

  // record of a finished datagram
  always_comb begin
    q_push       = accept & in_last_byte;
    q_rec.sum    = sum_nxt;
    q_rec.pend   = pend_nxt;
    q_rec.pseudo = pseudo_nxt;
    q_rec.hw     = hw_nxt;
    q_rec.total  = cnt_nxt;
    q_rec.gen    = generate_mode;
  end

  // state registers, cleared after the last byte except the held pseudo sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      cnt_r    <= '0;
      pend_r   <= '0;
      hw_r     <= '0;
      pseudo_r <= '0;
    end else if (accept) begin
      pseudo_r <= pseudo_nxt;
      if (in_last_byte) begin
        sum_r  <= '0;
        cnt_r  <= '0;
        pend_r <= '0;
        hw_r   <= '0;
      end else begin
        sum_r  <= sum_nxt;
        cnt_r  <= cnt_nxt;
        pend_r <= pend_nxt;
        hw_r   <= hw_nxt;
      end
    end
  end

endmodule

// ----- rtl/udc_queue.sv -----
// short queue of finished datagram records between front and back
// depends on udc_pkg for the record type and depth
module udc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  udc_pkg::rec_t  push_rec,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output udc_pkg::rec_t  head_rec
);
  import udc_pkg::*;

  rec_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_rec   = slot_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ----- rtl/udc_back.sv -----
// back part: finishes the checksum over a pipeline of ones'-complement adds and sets the status
// depends on udc_pkg; pops records from udc_queue and drives the result registers
module udc_back #(
  parameter int unsigned MAX_DATAGRAM_BYTES = udc_pkg::DEF_MAX_BYTES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  udc_pkg::rec_t  head_rec,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    out_checksum,
  output logic [15:0]    out_received_checksum,
  output logic [15:0]    out_length_field,
  output logic [15:0]    out_source_port,
  output logic [15:0]    out_dest_port,
  output logic [15:0]    out_byte_count,
  output logic [1:0]     out_status
);
  import udc_pkg::*;

  logic adv;

  // stage valids
  logic p1_v_r, p2_v_r, p3_v_r, p4_v_r, out_v_r;

  // stage 1: length bound, pad word and status precursor
  logic [31:0] p1_sum_r, p1_pad_r, p1_pseudo_r;
  info_t       p1_info_r;
  // stage 2: four partial sums
  logic [31:0] p2_a_r, p2_b_r, p2_c_r, p2_d_r;
  info_t       p2_info_r;
  // stage 3: two partial sums
  logic [31:0] p3_e_r, p3_f_r;
  info_t       p3_info_r;
  // stage 4: full sum
  logic [31:0] p4_s_r;
  info_t       p4_info_r;

  logic [15:0]        len;
  logic               bounded;
  logic [TOTAL_W-1:0] n_val;
  logic [31:0]        pad;
  logic [1:0]         pre;
  logic [16:0]        fold1;
  logic [15:0]        fold2;
  logic [15:0]        chk;
  logic [1:0]         status;

  logic [15:0] chk_r, rx_r, len_r, src_r, dst_r, cnt_r;
  logic [1:0]  status_r;

  // whole pipeline moves when the result register is free or being taken
  assign adv = ~out_v_r | out_ready;
  assign pop = adv & head_valid;

  // byte count used in the sum, odd-byte padding and length checks
  always_comb begin
    len     = head_rec.hw[HW_LEN];
    bounded = ~head_rec.gen & (len != 16'h0);
    if (32'(head_rec.total) > MAX_DATAGRAM_BYTES) begin
      n_val = TOTAL_W'(MAX_DATAGRAM_BYTES);
    end else begin
      n_val = head_rec.total;
    end
    if (bounded && (32'(len) >= HDR_BYTES) && (32'(n_val) > 32'(len))) begin
      n_val = TOTAL_W'(len);
    end
    if ((32'(n_val) > HDR_BYTES) && n_val[0]) begin
      pad = {16'h0, head_rec.pend, 8'h0};
    end else begin
      pad = 32'h0;
    end
    if (32'(head_rec.total) > MAX_DATAGRAM_BYTES) begin
      pre = ST_OVERSIZE;
    end else if (32'(head_rec.total) < HDR_BYTES) begin
      pre = ST_MALFORMED;
    end else if (bounded && ((32'(len) < HDR_BYTES) ||
                             (32'(len) > 32'(head_rec.total)))) begin
      pre = ST_MALFORMED;
    end else begin
      pre = ST_OK;
    end
  end

  // final fold, complement and mismatch check
  always_comb begin
    fold1 = {1'b0, p4_s_r[15:0]} + {1'b0, p4_s_r[31:16]};
    fold2 = fold1[15:0] + {15'h0, fold1[16]};
    chk   = ~fold2;
    if (chk == 16'h0) begin
      chk = 16'hFFFF;
    end
    if (p4_info_r.pre != ST_OK) begin
      status = p4_info_r.pre;
    end else if (p4_info_r.verify && (p4_info_r.hw[HW_CHK] != 16'h0) &&
                 (p4_info_r.hw[HW_CHK] != chk)) begin
      status = ST_MISMATCH;
    end else begin
      status = ST_OK;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      p3_v_r  <= 1'b0;
      p4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r  <= head_valid;
      p2_v_r  <= p1_v_r;
      p3_v_r  <= p2_v_r;
      p4_v_r  <= p3_v_r;
      out_v_r <= p4_v_r;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_sum_r         <= head_rec.sum;
      p1_pad_r         <= pad;
      p1_pseudo_r      <= head_rec.pseudo;
      p1_info_r.n16    <= 16'(n_val);
      p1_info_r.hw     <= head_rec.hw;
      p1_info_r.pre    <= pre;
      p1_info_r.verify <= ~head_rec.gen;

      p2_a_r    <= add_oc(p1_sum_r, p1_pad_r);
      p2_b_r    <= add_oc(p1_pseudo_r, {16'h0, p1_info_r.n16});
      p2_c_r    <= add_oc(UDP_PROTO, {16'h0, p1_info_r.hw[HW_SRC]});
      p2_d_r    <= add_oc({16'h0, p1_info_r.hw[HW_DST]}, {16'h0, p1_info_r.hw[HW_LEN]});
      p2_info_r <= p1_info_r;

      p3_e_r    <= add_oc(p2_a_r, p2_b_r);
      p3_f_r    <= add_oc(p2_c_r, p2_d_r);
      p3_info_r <= p2_info_r;

      p4_s_r    <= add_oc(p3_e_r, p3_f_r);
      p4_info_r <= p3_info_r;

      chk_r    <= chk;
      rx_r     <= p4_info_r.hw[HW_CHK];
      len_r    <= p4_info_r.hw[HW_LEN];
      src_r    <= p4_info_r.hw[HW_SRC];
      dst_r    <= p4_info_r.hw[HW_DST];
      cnt_r    <= p4_info_r.n16;
      status_r <= status;
    end
  end

  assign out_valid             = out_v_r;
  assign out_checksum          = chk_r;
  assign out_received_checksum = rx_r;
  assign out_length_field      = len_r;
  assign out_source_port       = src_r;
  assign out_dest_port         = dst_r;
  assign out_byte_count        = cnt_r;
  assign out_status            = status_r;

endmodule

// ----- rtl/udp_datagram_checksum_checker.sv -----
// udp checksum checker / generator top level: mode register, front, queue and back
// depends on udc_pkg, udc_front, udc_queue and udc_back
//
//  channel | signals                                   | direction | transaction
//  in_     | in_valid/in_ready, byte, marks, pseudo sum | input     | one datagram byte
//  out_    | out_valid/out_ready, checksum, header, ... | output    | one result per last byte
//  cfg_    | cfg_valid/cfg_ready, cfg_generate_mode     | input     | mode register write
//
// one byte is taken per cycle while in_ready is high; every second payload byte
// costs one 32-bit end-around add in the front; results leave at up to one per cycle
// the back pipeline stalls only on out_ready; the 4-entry queue then fills and
// in_ready drops when it is full
// reset (rst_n low, synchronous) clears the mode, the datagram state and all valids
module udp_datagram_checksum_checker #(
  parameter int unsigned MAX_DATAGRAM_BYTES = udc_pkg::DEF_MAX_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_generate_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic [31:0] in_pseudo_sum,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_checksum,
  output logic [15:0] out_received_checksum,
  output logic [15:0] out_length_field,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic [15:0] out_byte_count,
  output logic [1:0]  out_status
);
  import udc_pkg::*;

  logic gen_mode_r;
  logic q_full, q_push, q_pop, q_head_valid;
  rec_t q_rec, q_head_rec;

  // mode register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      gen_mode_r <= cfg_generate_mode;
    end
  end

  udc_front #(
    .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .generate_mode (gen_mode_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .in_pseudo_sum (in_pseudo_sum),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_rec         (q_rec)
  );

  udc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_rec   (q_rec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_rec   (q_head_rec)
  );

  udc_back #(
    .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head_valid            (q_head_valid),
    .head_rec              (q_head_rec),
    .pop                   (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_checksum          (out_checksum),
    .out_received_checksum (out_received_checksum),
    .out_length_field      (out_length_field),
    .out_source_port       (out_source_port),
    .out_dest_port         (out_dest_port),
    .out_byte_count        (out_byte_count),
    .out_status            (out_status)
  );

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for udp_datagram_checksum_checker: byte stream in, checksum reports out
// depends on udc_pkg and the udp_datagram_checksum_checker rtl; predicts each report locally
`timescale 1ns / 1ps

module testbench;
  import udc_pkg::*;

  localparam int unsigned MAX_BYTES = DEF_MAX_BYTES;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 1000000;

  // one checksum report as the block gives it
  typedef struct packed {
    logic [15:0] checksum;
    logic [15:0] received_checksum;
    logic [15:0] length_field;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] byte_count;
    logic [1:0]  status;
  } udp_report_t;

  // running checksum state of the datagram in progress, plus the mode
  typedef struct packed {
    logic             gen;
    logic [31:0]      acc;
    logic [16:0]      seen;
    logic [7:0]       pend;
    logic [3:0][15:0] hdr;
    logic [31:0]      held;
  } cksum_state_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_generate_mode;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_first_byte;
  logic        in_last_byte;
  logic [31:0] in_pseudo_sum;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_checksum;
  logic [15:0] out_received_checksum;
  logic [15:0] out_length_field;
  logic [15:0] out_source_port;
  logic [15:0] out_dest_port;
  logic [15:0] out_byte_count;
  logic [1:0]  out_status;

  cksum_state_t checker_state;
  udp_report_t  expected_reports[$];
  logic [7:0]   dgram[$];
  int           fail_count;
  int           cycle_count;
  int           bytes_accepted;
  int           burst_left;
  bit           sender_idle_en;
  int           rx_mode;
  int           rx_cycle;
  int           stall_left;

  udp_datagram_checksum_checker u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_generate_mode     (cfg_generate_mode),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_byte          (in_data_byte),
    .in_first_byte         (in_first_byte),
    .in_last_byte          (in_last_byte),
    .in_pseudo_sum         (in_pseudo_sum),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_checksum          (out_checksum),
    .out_received_checksum (out_received_checksum),
    .out_length_field      (out_length_field),
    .out_source_port       (out_source_port),
    .out_dest_port         (out_dest_port),
    .out_byte_count        (out_byte_count),
    .out_status            (out_status)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ones'-complement add on 32 bits, carry wraps around
  function automatic logic [31:0] ones_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[31:0] + {31'h0, t[32]};
  endfunction

  // advance the checksum state by one byte; returns 1 with a report on a last byte
  function automatic bit step_checksum(inout cksum_state_t st, input logic [7:0] b,
                                       input bit first, input bit last,
                                       input logic [31:0] ps, output udp_report_t rep);
    logic [31:0] idx;
    logic [31:0] len;
    logic [31:0] total;
    logic [31:0] n;
    logic [31:0] s;
    logic [31:0] x;
    logic [15:0] w;
    logic [15:0] chk;
    bit          bounded;
    rep = '0;
    if (first) begin
      st.acc = '0;
      st.seen = '0;
      st.pend = '0;
      st.hdr = '0;
      st.held = ps;
    end
    idx = {15'h0, st.seen};
    len = {16'h0, st.hdr[HW_LEN]};
    bounded = !st.gen && (len != 0);
    // header bytes fill the header words, payload pairs go into the sum
    if (idx < MAX_BYTES) begin
      if (idx < HDR_BYTES) begin
        w = st.hdr[idx[2:1]];
        if (idx[0] == 1'b0) w[15:8] = b;
        else w[7:0] = b;
        st.hdr[idx[2:1]] = w;
      end else if (!bounded || idx < len) begin
        if (idx[0] == 1'b0) st.pend = b;
        else st.acc = ones_add(st.acc, {16'h0, st.pend, b});
      end
    end
    if (st.seen <= MAX_BYTES) st.seen = st.seen + 1'b1;
    if (!last) return 1'b0;

    // summed byte count, capped by the size limit and the length bound
    total = {15'h0, st.seen};
    len = {16'h0, st.hdr[HW_LEN]};
    bounded = !st.gen && (len != 0);
    n = (total > MAX_BYTES) ? MAX_BYTES : total;
    if (bounded && len >= HDR_BYTES && n > len) n = len;

    // pad, pseudo header, protocol and header words, then fold twice
    s = st.acc;
    if (n > HDR_BYTES && n[0]) s = ones_add(s, {16'h0, st.pend, 8'h00});
    s = ones_add(s, st.held);
    s = ones_add(s, {16'h0, n[15:0]});
    s = ones_add(s, UDP_PROTO);
    s = ones_add(s, {16'h0, st.hdr[HW_SRC]});
    s = ones_add(s, {16'h0, st.hdr[HW_DST]});
    s = ones_add(s, {16'h0, st.hdr[HW_LEN]});
    x = {16'h0, s[15:0]} + {16'h0, s[31:16]};
    x = {16'h0, x[15:0]} + {16'h0, x[31:16]};
    chk = ~x[15:0];
    if (chk == 16'h0) chk = 16'hFFFF;

    // oversize wins over malformed, malformed over mismatch
    if (total > MAX_BYTES) rep.status = ST_OVERSIZE;
    else if (total < HDR_BYTES) rep.status = ST_MALFORMED;
    else if (bounded && (len < HDR_BYTES || len > total)) rep.status = ST_MALFORMED;
    else if (!st.gen && st.hdr[HW_CHK] != 16'h0 && st.hdr[HW_CHK] != chk)
      rep.status = ST_MISMATCH;
    else rep.status = ST_OK;

    rep.checksum = chk;
    rep.received_checksum = st.hdr[HW_CHK];
    rep.length_field = st.hdr[HW_LEN];
    rep.source_port = st.hdr[HW_SRC];
    rep.dest_port = st.hdr[HW_DST];
    rep.byte_count = n[15:0];
    st.acc = '0;
    st.seen = '0;
    st.pend = '0;
    st.hdr = '0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_pseudo();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endfunction

  // one byte transaction, with the sender's burst and gap pattern
  task automatic send_byte(input logic [7:0] b, input bit first, input bit last,
                           input logic [31:0] ps);
    int          gap;
    udp_report_t rep;
    gap = 0;
    if (sender_idle_en && burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_first_byte <= first;
    in_last_byte <= last;
    in_pseudo_sum <= ps;
    do @(posedge clk); while (!in_ready);
    bytes_accepted++;
    if (step_checksum(checker_state, b, first, last, ps, rep)) expected_reports.push_back(rep);
  endtask

  // mode register write, only once every report is out and the pipeline is empty
  task automatic write_mode(input bit mode);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_generate_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    checker_state.gen = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // header with random ports, correct length, zero checksum, random payload
  task automatic build_dgram(input int pay);
    logic [31:0] total;
    logic [15:0] sp;
    logic [15:0] dp;
    total = 8 + pay;
    sp = 16'($urandom);
    dp = 16'($urandom);
    dgram.delete();
    dgram.push_back(sp[15:8]);
    dgram.push_back(sp[7:0]);
    dgram.push_back(dp[15:8]);
    dgram.push_back(dp[7:0]);
    dgram.push_back(total[15:8]);
    dgram.push_back(total[7:0]);
    dgram.push_back(8'h00);
    dgram.push_back(8'h00);
    repeat (pay) dgram.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic set_word(input int pos, input logic [15:0] val);
    dgram[2 * pos] = val[15:8];
    dgram[2 * pos + 1] = val[7:0];
  endtask

  task automatic trim_dgram(input int keep);
    while (dgram.size() > keep) void'(dgram.pop_back());
  endtask

  // put the checksum the block would compute into the header field
  task automatic fix_checksum(input bit mark_first, input logic [31:0] ps);
    cksum_state_t st;
    udp_report_t  rep;
    bit           got;
    st = checker_state;
    got = 1'b0;
    for (int i = 0; i < dgram.size(); i++)
      got = step_checksum(st, dgram[i], mark_first && i == 0, i == dgram.size() - 1, ps, rep);
    if (got) set_word(HW_CHK, rep.checksum);
  endtask

  task automatic send_dgram(input bit mark_first, input bit mark_last, input logic [31:0] ps);
    for (int i = 0; i < dgram.size(); i++)
      send_byte(dgram[i], mark_first && i == 0, mark_last && i == dgram.size() - 1,
                (i == 0) ? ps : $urandom);
  endtask

  // mostly sound datagram, with occasional odd length or checksum fields
  task automatic send_wellformed();
    int          pay;
    int          pick;
    logic [31:0] ps;
    pay = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
    build_dgram(pay);
    ps = rand_pseudo();
    pick = $urandom_range(0, 19);
    if (pick == 0) set_word(HW_LEN, 16'h0);
    else if (pick == 1) set_word(HW_LEN, 16'($urandom_range(0, 7)));
    else if (pick == 2) set_word(HW_LEN, 16'(8 + pay + $urandom_range(1, 20)));
    else if (pick == 3) set_word(HW_LEN, 16'($urandom_range(8, 8 + pay)));
    else if (pick == 4) set_word(HW_LEN, 16'($urandom));
    pick = $urandom_range(0, 9);
    if (pick < 7) fix_checksum(1'b1, ps);
    else if (pick == 7) set_word(HW_CHK, 16'h0);
    else set_word(HW_CHK, 16'($urandom));
    send_dgram(1'b1, 1'b1, ps);
  endtask

  // verify mode: good, bad and absent checksums, length bounds, broken marks
  task automatic test_verify_directed();
    logic [31:0] ps;
    logic [15:0] chk0;
    write_mode(1'b0);
    // smallest datagram, extreme ports, zero pseudo sum
    build_dgram(0);
    set_word(HW_SRC, 16'hFFFF);
    set_word(HW_DST, 16'h0000);
    fix_checksum(1'b1, 32'h0);
    send_dgram(1'b1, 1'b1, 32'h0);
    // odd payload, all-ones pseudo sum
    build_dgram(5);
    fix_checksum(1'b1, 32'hFFFF_FFFF);
    send_dgram(1'b1, 1'b1, 32'hFFFF_FFFF);
    // wrong checksum
    build_dgram(5);
    fix_checksum(1'b1, 32'h1234_5678);
    set_word(HW_CHK, {dgram[6], dgram[7]} ^ 16'h0101);
    send_dgram(1'b1, 1'b1, 32'h1234_5678);
    // checksum not computed by the sender
    build_dgram(3);
    send_dgram(1'b1, 1'b1, rand_pseudo());
    // payload chosen so the computed sum is zero and reads back as all ones
    ps = $urandom;
    build_dgram(2);
    dgram[8] = 8'h00;
    dgram[9] = 8'h00;
    fix_checksum(1'b1, ps);
    chk0 = {dgram[6], dgram[7]};
    dgram[8] = chk0[15:8];
    dgram[9] = chk0[7:0];
    set_word(HW_CHK, 16'hFFFF);
    send_dgram(1'b1, 1'b1, ps);
    // length field zero: everything summed
    build_dgram(4);
    set_word(HW_LEN, 16'h0);
    fix_checksum(1'b1, ps);
    send_dgram(1'b1, 1'b1, ps);
    // odd length bound below the received count, trailing bytes ignored
    build_dgram(6);
    set_word(HW_LEN, 16'd11);
    fix_checksum(1'b1, ps);
    send_dgram(1'b1, 1'b1, ps);
    // length under the header size
    build_dgram(2);
    set_word(HW_LEN, 16'd5);
    send_dgram(1'b1, 1'b1, ps);
    // length past the received bytes
    build_dgram(2);
    set_word(HW_LEN, 16'd13);
    send_dgram(1'b1, 1'b1, ps);
    // one byte with both marks
    send_byte(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // truncated header
    build_dgram(0);
    trim_dgram(7);
    send_dgram(1'b1, 1'b1, ps);
    // new first mark in the middle of a datagram
    build_dgram(0);
    trim_dgram(5);
    send_dgram(1'b1, 1'b0, ps);
    build_dgram(1);
    fix_checksum(1'b1, ps);
    send_dgram(1'b1, 1'b1, ps);
    // no first mark after a last byte: held pseudo sum reused
    build_dgram(2);
    dgram[8] = 8'hFF;
    dgram[9] = 8'hFF;
    fix_checksum(1'b0, 32'h0);
    send_dgram(1'b0, 1'b1, 32'h0);
  endtask

  // generate mode: length and checksum fields do not matter
  task automatic test_generate_directed();
    write_mode(1'b1);
    build_dgram(5);
    set_word(HW_LEN, 16'd3);
    send_dgram(1'b1, 1'b1, rand_pseudo());
    build_dgram(4);
    set_word(HW_CHK, 16'h1235);
    send_dgram(1'b1, 1'b1, rand_pseudo());
    build_dgram(0);
    trim_dgram(4);
    send_dgram(1'b1, 1'b1, rand_pseudo());
  endtask

  // phases in alternating modes of mostly sound datagrams plus broken traffic
  task automatic test_random_traffic();
    int phase_start;
    int kind;
    int cnt;
    for (int phase = 0; phase < 6; phase++) begin
      write_mode(phase[0]);
      sender_idle_en = ($urandom_range(0, 3) != 0);
      phase_start = bytes_accepted;
      while (bytes_accepted - phase_start < 170) begin
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
          send_wellformed();
        end else if (kind == 7) begin
          // truncated datagram
          build_dgram(0);
          trim_dgram($urandom_range(1, 7));
          send_dgram(1'b1, 1'b1, rand_pseudo());
        end else if (kind == 8) begin
          build_dgram($urandom_range(0, 12));
          if ($urandom_range(0, 1) == 0) begin
            // abandoned partial datagram
            trim_dgram($urandom_range(1, dgram.size()));
            send_dgram(1'b1, 1'b0, rand_pseudo());
          end else begin
            // datagram without first mark
            fix_checksum(1'b0, 32'h0);
            send_dgram(1'b0, 1'b1, $urandom);
          end
        end else begin
          // noise bytes with random marks
          cnt = $urandom_range(1, 6);
          repeat (cnt)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 3) == 0, rand_pseudo());
        end
      end
      send_wellformed();
    end
  endtask

  // receiver stall pattern that switches at random between always ready, short stalls and long stalls
  initial begin
    out_ready = 1'b0;
    rx_mode = 0;
    rx_cycle = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (rx_mode == 1 && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else if (rx_mode == 2 && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 19);
      end else begin
        out_ready <= 1'b1;
      end
      rx_cycle++;
      if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
    end
  end

  // compare each report transaction with the oldest prediction
  always @(posedge clk) begin : report_check
    udp_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $error("report with no prediction waiting");
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("checksum", want.checksum, out_checksum);
        check_field("received_checksum", want.received_checksum, out_received_checksum);
        check_field("length_field", want.length_field, out_length_field);
        check_field("source_port", want.source_port, out_source_port);
        check_field("dest_port", want.dest_port, out_dest_port);
        check_field("byte_count", want.byte_count, out_byte_count);
        check_field("status", {14'h0, want.status}, {14'h0, out_status});
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // reset, tests in turn, drain and verdict
  initial begin : main
    int waited;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_generate_mode = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h0;
    in_first_byte = 1'b0;
    in_last_byte = 1'b0;
    in_pseudo_sum = 32'h0;
    checker_state = '0;
    fail_count = 0;
    cycle_count = 0;
    bytes_accepted = 0;
    burst_left = 0;
    sender_idle_en = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_verify_directed();
    test_generate_directed();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_reports.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_reports.size() != 0) begin
      $error("%0d predicted reports never arrived", expected_reports.size());
      fail_count++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- udp_datagram_checksum_checker.f -----
rtl/udc_pkg.sv
rtl/udc_front.sv
rtl/udc_queue.sv
rtl/udc_back.sv
rtl/udp_datagram_checksum_checker.sv
tb/testbench.sv
